// File: rtl/core/tfj_pkg.sv
// ----------------------------------------------------------------------------
// tfj_pkg: shared types and constants of the text full justifier
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tfj_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int MAX_WORDS = 16;
    localparam int DIV_STEPS = 6;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [5:0] WIDTH_RESET = 6'd32;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_TAKE,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_EMIT_INIT,
        CMD_LETTER,
        CMD_GAP_OPEN,
        CMD_SPACE,
        CMD_CLEAR,
        CMD_COPY_STEP,
        CMD_WORD_DONE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    last;
    } cmd_t;

    typedef struct packed {
        logic need_emit;
        logic div_done;
        logic letter_avail;
        logic more_words;
        logic gap_zero;
        logic line_done;
        logic out_ready;
        logic copy_more;
    } status_t;

endpackage

// File: rtl/core/tfj_ctrl.sv
// ----------------------------------------------------------------------------
// tfj_ctrl: sequencing state machine
// Steps the datapath through take, check, divide, emit, clear and copy.
// ----------------------------------------------------------------------------
module tfj_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            word_end,
    input  logic            text_end,
    input  tfj_pkg::status_t sts,
    output tfj_pkg::cmd_t   cmd
);
    import tfj_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_LETTERS,
        S_GAP,
        S_PAD,
        S_ENDLINE,
        S_COPY
    } state_t;

    state_t state_reg, state_next;
    logic   text_end_reg, text_end_next;
    logic   last_reg, last_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        text_end_next = text_end_reg;
        last_next     = last_reg;
        cmd.op        = CMD_NONE;
        cmd.last      = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = CMD_TAKE;
                    if (word_end)
                    begin
                        text_end_next = text_end;
                        state_next    = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.need_emit)
                begin
                    last_next  = 1'b0;
                    cmd.last   = 1'b0;
                    cmd.op     = CMD_DIV_INIT;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_COPY;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = CMD_EMIT_INIT;
                    state_next = S_LETTERS;
                end
                else
                begin
                    cmd.op = CMD_DIV_STEP;
                end
            end
            S_LETTERS:
            begin
                if (sts.line_done)
                    state_next = S_ENDLINE;
                else if (sts.letter_avail)
                begin
                    if (sts.out_ready)
                        cmd.op = CMD_LETTER;
                end
                else if (sts.more_words)
                begin
                    cmd.op     = CMD_GAP_OPEN;
                    state_next = S_GAP;
                end
                else
                    state_next = S_PAD;
            end
            S_GAP:
            begin
                if (sts.line_done)
                    state_next = S_ENDLINE;
                else if (sts.gap_zero)
                    state_next = S_LETTERS;
                else if (sts.out_ready)
                    cmd.op = CMD_SPACE;
            end
            S_PAD:
            begin
                if (sts.line_done)
                    state_next = S_ENDLINE;
                else if (sts.out_ready)
                    cmd.op = CMD_SPACE;
            end
            S_ENDLINE:
            begin
                cmd.op = CMD_CLEAR;
                if (last_reg)
                    state_next = S_IDLE;
                else
                    state_next = S_COPY;
            end
            S_COPY:
            begin
                if (sts.copy_more)
                    cmd.op = CMD_COPY_STEP;
                else
                begin
                    cmd.op = CMD_WORD_DONE;
                    if (text_end_reg)
                    begin
                        state_next = S_DIV;
                        last_next  = 1'b1;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // the final line starts its divide from the word-done cycle
        if (state_reg == S_COPY && !sts.copy_more && text_end_reg)
            cmd.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            text_end_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            text_end_reg <= text_end_next;
            last_reg     <= last_next;
        end
    end

endmodule

// File: rtl/core/tfj_dp.sv
// ----------------------------------------------------------------------------
// tfj_dp: justifier datapath
// Word and line stores, counters, gap divider and output register.
// ----------------------------------------------------------------------------
module tfj_dp
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             line_width_wr,
    input  logic [5:0]       line_width,
    input  logic [7:0]       character,
    input  tfj_pkg::cmd_t    cmd,
    output tfj_pkg::status_t sts,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_char,
    output logic             line_end,
    output logic             text_done
);
    import tfj_pkg::*;

    logic [7:0] pend_mem [MAX_WIDTH];
    logic [7:0] line_mem [MAX_WIDTH];
    logic [5:0] wep_mem  [MAX_WORDS];

    logic [5:0] width_reg;
    logic [5:0] w;
    logic [4:0] words_reg;
    logic [5:0] letters_reg;
    logic [5:0] plen_reg;
    logic [5:0] cidx_reg;
    logic [3:0] widx_reg;
    logic [5:0] j_reg;
    logic [5:0] p_reg;
    logic [5:0] gap_reg;
    logic [5:0] sp_reg;
    logic [4:0] extra_reg;
    logic       last_reg;
    logic       just_reg;
    logic [5:0] dq_reg;
    logic [4:0] rem_reg;
    logic [4:0] div_reg;
    logic [2:0] dcnt_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       line_end_reg;
    logic       text_done_reg;
    logic [5:0] wep_q;
    logic [7:0] line_q;

    logic [6:0] fill_sum;
    logic [6:0] copy_pos;
    logic [6:0] let_sum;
    logic [5:0] let_new;
    logic [4:0] gaps;
    logic [5:0] trial;
    logic       fits;
    logic       emit_out;
    logic [7:0] emit_char;

    always_comb
    begin
        if (width_reg == 6'd0)
            w = 6'd1;
        else if (width_reg > 6'(MAX_WIDTH))
            w = 6'(MAX_WIDTH);
        else
            w = width_reg;
    end

    assign gaps     = words_reg - 5'd1;
    assign fill_sum = 7'(letters_reg) + 7'(words_reg) + 7'(plen_reg);
    assign copy_pos = 7'(letters_reg) + 7'(cidx_reg);
    assign let_sum  = 7'(letters_reg) + 7'(plen_reg);
    assign let_new  = (let_sum > 7'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : let_sum[5:0];
    assign fits     = (7'(letters_reg) + 7'(gaps)) <= 7'(w);
    assign trial    = {rem_reg, dq_reg[5]};

    assign sts.need_emit    = (words_reg != 5'd0) &&
                              ((fill_sum > 7'(w)) || (words_reg >= 5'(MAX_WORDS)));
    assign sts.div_done     = (dcnt_reg == 3'd0);
    assign sts.letter_avail = j_reg < wep_q;
    assign sts.more_words   = (5'(widx_reg) + 5'd1) < words_reg;
    assign sts.gap_zero     = (gap_reg == 6'd0);
    assign sts.line_done    = (p_reg == w);
    assign sts.out_ready    = !out_valid_reg || !out_stall;
    assign sts.copy_more    = cidx_reg < plen_reg;

    assign emit_out  = (cmd.op == CMD_LETTER) || (cmd.op == CMD_SPACE);
    assign emit_char = (cmd.op == CMD_LETTER) ? line_q : SPACE_CHAR;

    // storage arrays: no reset, every read entry is written first;
    // reads fetch the entry that emission needs next
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_TAKE && plen_reg < w)
            pend_mem[plen_reg[4:0]] <= character;
        if (cmd.op == CMD_COPY_STEP && copy_pos < 7'(MAX_WIDTH))
            line_mem[copy_pos[4:0]] <= pend_mem[cidx_reg[4:0]];
        if (cmd.op == CMD_WORD_DONE && words_reg < 5'(MAX_WORDS))
            wep_mem[words_reg[3:0]] <= let_new;
        if (cmd.op == CMD_EMIT_INIT)
        begin
            wep_q  <= wep_mem[4'd0];
            line_q <= line_mem[5'd0];
        end
        if (cmd.op == CMD_GAP_OPEN)
            wep_q <= wep_mem[widx_reg + 4'd1];
        if (cmd.op == CMD_LETTER)
            line_q <= line_mem[j_reg[4:0] + 5'd1];
    end

    // payload-only registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_DIV_INIT, CMD_WORD_DONE:
            begin
                last_reg <= cmd.last;
                just_reg <= !cmd.last && (words_reg > 5'd1) && fits;
                dq_reg   <= w - letters_reg;
                div_reg  <= gaps;
                rem_reg  <= 5'd0;
            end
            CMD_DIV_STEP:
            begin
                if (trial >= 6'(div_reg))
                begin
                    rem_reg <= 5'(trial - 6'(div_reg));
                    dq_reg  <= {dq_reg[4:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[4:0];
                    dq_reg  <= {dq_reg[4:0], 1'b0};
                end
            end
            CMD_EMIT_INIT:
            begin
                widx_reg  <= 4'd0;
                j_reg     <= 6'd0;
                p_reg     <= 6'd0;
                gap_reg   <= 6'd0;
                sp_reg    <= just_reg ? dq_reg : 6'd1;
                extra_reg <= just_reg ? rem_reg : 5'd0;
            end
            CMD_LETTER:
            begin
                j_reg <= j_reg + 6'd1;
                p_reg <= p_reg + 6'd1;
            end
            CMD_GAP_OPEN:
            begin
                widx_reg <= widx_reg + 4'd1;
                if (extra_reg != 5'd0)
                begin
                    gap_reg   <= sp_reg + 6'd1;
                    extra_reg <= extra_reg - 5'd1;
                end
                else
                    gap_reg <= sp_reg;
            end
            CMD_SPACE:
            begin
                gap_reg <= gap_reg - 6'd1;
                p_reg   <= p_reg + 6'd1;
            end
            default:
            begin
            end
        endcase
        if (emit_out)
        begin
            out_char_reg  <= emit_char;
            line_end_reg  <= (p_reg == w - 6'd1);
            text_done_reg <= last_reg && (p_reg == w - 6'd1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            words_reg     <= 5'd0;
            letters_reg   <= 6'd0;
            plen_reg      <= 6'd0;
            cidx_reg      <= 6'd0;
            dcnt_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (line_width_wr)
                width_reg <= line_width;
            case (cmd.op)
                CMD_TAKE:
                begin
                    cidx_reg <= 6'd0;
                    if (plen_reg < w)
                        plen_reg <= plen_reg + 6'd1;
                end
                CMD_DIV_INIT, CMD_WORD_DONE:
                begin
                    dcnt_reg <= 3'(DIV_STEPS);
                    if (cmd.op == CMD_WORD_DONE)
                    begin
                        letters_reg <= let_new;
                        plen_reg    <= 6'd0;
                        if (words_reg < 5'(MAX_WORDS))
                            words_reg <= words_reg + 5'd1;
                    end
                end
                CMD_DIV_STEP:
                    dcnt_reg <= dcnt_reg - 3'd1;
                CMD_CLEAR:
                begin
                    words_reg   <= 5'd0;
                    letters_reg <= 6'd0;
                    cidx_reg    <= 6'd0;
                end
                CMD_COPY_STEP:
                    cidx_reg <= cidx_reg + 6'd1;
                default:
                begin
                end
            endcase
            if (emit_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign line_end  = line_end_reg;
    assign text_done = text_done_reg;

endmodule

// File: rtl/core/text_full_justifier_top.sv
// ----------------------------------------------------------------------------
// text_full_justifier_top: greedy full justification of a byte stream
// Packs words into lines of line_width bytes (clamped to 1..32) and streams them out justified.
// ----------------------------------------------------------------------------
//
//  port group    dir  handshake            payload
//  ------------  ---  -------------------  --------------------------------
//  input words   in   in_valid/in_stall    character, word_end, text_end
//  output words  out  out_valid/out_stall  out_char, line_end, text_done
//  config        in   line_width_wr        line_width
//
//  Bytes inside a word are taken while in_stall is low. At a word end the
//  block checks the held line; when the word does not fit or the line holds
//  MAX_WORDS words, 6 divider steps and a setup step follow, then the line's
//  bytes and gaps are emitted, padded with spaces, and the line is cleared;
//  then the word is copied into the line.
//  On text end the final line follows the same way, but with single spaces. The output port's
//  single register and the line length set the pace of emission.
//  Reset clears counters, width (to 32) and handshakes; stores need none.
//  out_stall holds the output register and pauses emission.
//
module text_full_justifier_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       line_width_wr,
    input  logic [5:0] line_width,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] character,
    input  logic       word_end,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       line_end,
    output logic       text_done
);
    import tfj_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // sequence the work of each word
    tfj_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .word_end (word_end),
        .text_end (text_end),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold stores, counters and the output register
    tfj_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_width_wr (line_width_wr),
        .line_width    (line_width),
        .character     (character),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .line_end      (line_end),
        .text_done     (text_done)
    );

endmodule

// File: tb/sv/text_full_justifier_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_full_justifier_top_test: self-checking bench of the text justifier
// Streams words through the block under random idle and stall, predicts every
// justified line in the bench and compares each output word field by field.
// ----------------------------------------------------------------------------
module text_full_justifier_top_test;
    import tfj_pkg::*;

    typedef struct packed {
        logic [7:0] character;
        logic       word_end;
        logic       text_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       line_end;
        logic       text_done;
    } out_word_t;

    localparam int STALL_LIMIT = 4000;

    logic       clk;
    logic       rst_n;
    logic       line_width_wr;
    logic [5:0] line_width;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] character;
    logic       word_end;
    logic       text_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_char;
    logic       line_end;
    logic       text_done;

    text_full_justifier_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .line_width_wr (line_width_wr),
        .line_width    (line_width),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .character     (character),
        .word_end      (word_end),
        .text_end      (text_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .line_end      (line_end),
        .text_done     (text_done)
    );

    // Bench copy of the justifier state.
    logic [7:0] line_letters [MAX_WIDTH];
    logic [5:0] word_ends    [MAX_WORDS];
    int unsigned n_words;
    int unsigned n_letters;
    logic [7:0] word_buf     [MAX_WIDTH];
    int unsigned word_len;
    logic [5:0] width_reg;

    in_word_t  pending_words[$];
    out_word_t expected_chars[$];
    bit        failed = 1'b0;
    bit        calm;      // long stretch with no idling on either side
    bit        in_accepted = 1'b0;
    int        idle_cycles = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned width_now();
        int unsigned w;
        w = 32'(width_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic void push_char(ref int unsigned p, input int unsigned w,
                                      input logic [7:0] c, input bit last);
        out_word_t o;
        if (p >= w) return;
        o.out_char  = c;
        o.line_end  = (p == w - 1);
        o.text_done = last && (p == w - 1);
        expected_chars = {expected_chars, o};
        p++;
    endfunction

    // Lay out the held line: justified unless last, single word or too long.
    function automatic void justify_line(input bit last);
        int unsigned w, n, sp, extra, p, start, e;
        w = width_now();
        n = n_words;
        sp = 1;
        extra = 0;
        p = 0;
        start = 0;
        if (!last && n > 1 && n_letters + n - 1 <= w)
        begin
            sp = (w - n_letters) / (n - 1);
            extra = (w - n_letters) % (n - 1);
        end
        for (int i = 0; i < n; i++)
        begin
            e = word_ends[i];
            if (i > 0)
            begin
                for (int s = 0; s < sp; s++) push_char(p, w, SPACE_CHAR, last);
                if (extra > 0)
                begin
                    push_char(p, w, SPACE_CHAR, last);
                    extra--;
                end
            end
            for (int j = start; j < e && j < MAX_WIDTH; j++)
                push_char(p, w, line_letters[j], last);
            start = e;
        end
        while (p < w) push_char(p, w, SPACE_CHAR, last);
        n_words = 0;
        n_letters = 0;
    endfunction

    function automatic void predict_word(input in_word_t iw);
        int unsigned w;
        w = width_now();
        if (word_len < w) word_buf[word_len++] = iw.character;
        if (!iw.word_end) return;
        if (n_words > 0 && (n_letters + n_words + word_len > w || n_words >= MAX_WORDS))
            justify_line(1'b0);
        for (int i = 0; i < word_len; i++)
            if (n_letters + i < MAX_WIDTH) line_letters[n_letters + i] = word_buf[i];
        n_letters += word_len;
        if (n_letters > MAX_WIDTH) n_letters = MAX_WIDTH;
        if (n_words < MAX_WORDS) word_ends[n_words++] = n_letters[5:0];
        word_len = 0;
        if (iw.text_end) justify_line(1'b1);
    endfunction

    // Driver: advance to the next queued word on acceptance, idle at random.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_accepted)
            begin
                if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 27))
                begin
                    {character, word_end, text_end} <= pending_words[0];
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    // Drop words from the queue as they are accepted, and predict them.
    always @(posedge clk)
    begin
        in_accepted = rst_n && in_valid && !in_stall;
        if (in_accepted)
        begin
            predict_word(pending_words.pop_front());
            idle_cycles <= 0;
        end
        else if (rst_n && out_valid && !out_stall)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Monitor: compare each output word with the oldest expectation.
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected output word %h", out_char);
                failed = 1'b1;
            end
            else
            begin
                e = expected_chars.pop_front();
                if (out_char !== e.out_char)
                begin
                    $error("out_char expected %h actual %h", e.out_char, out_char);
                    failed = 1'b1;
                end
                if (line_end !== e.line_end)
                begin
                    $error("line_end expected %b actual %b", e.line_end, line_end);
                    failed = 1'b1;
                end
                if (text_done !== e.text_done)
                begin
                    $error("text_done expected %b actual %b", e.text_done, text_done);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Queue one word of len bytes; random letters, never a space.
    task automatic queue_word(input int len, input bit last);
        in_word_t iw;
        for (int i = 0; i < len; i++)
        begin
            iw.character = 8'($urandom_range(255));
            if (iw.character == SPACE_CHAR) iw.character = 8'h21;
            iw.word_end = (i == len - 1);
            // text_end away from a word end is noise the block ignores
            iw.text_end = iw.word_end ? last : ($urandom_range(9) == 0);
            pending_words = {pending_words, iw};
        end
    endtask

    // Wait until the block is idle, then write the width.
    task automatic set_width(input logic [5:0] w);
        while (pending_words.size() > 0 || expected_chars.size() > 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
        @(negedge clk);
        line_width_wr <= 1'b1;
        line_width    <= w;
        @(negedge clk);
        line_width_wr <= 1'b0;
        width_reg = w;
    endtask

    task automatic random_text(input int words, input int maxlen);
        for (int i = 0; i < words; i++)
            queue_word($urandom_range(maxlen, 1), i == words - 1);
    endtask

    initial
    begin
        in_word_t iw;
        calm = 1'b0;
        rst_n = 1'b0;
        line_width_wr = 1'b0;
        line_width = 6'd32;
        in_valid = 1'b0;
        character = 8'h00;
        word_end = 1'b0;
        text_end = 1'b0;
        out_stall = 1'b0;
        n_words = 0;
        n_letters = 0;
        word_len = 0;
        width_reg = WIDTH_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: byte extremes, full line, one-word line, long clipped word.
        iw = '{8'h00, 1'b1, 1'b0};
        pending_words = {pending_words, iw};
        iw = '{8'hFF, 1'b1, 1'b0};
        pending_words = {pending_words, iw};
        queue_word(5, 1'b0);
        queue_word(30, 1'b0);
        queue_word(3, 1'b1);
        // Sixteen one-letter words force a line full of words.
        set_width(6'd32);
        for (int i = 0; i < 17; i++) queue_word(1, i == 16);
        set_width(6'd0);
        queue_word(1, 1'b0);
        queue_word(3, 1'b1);
        set_width(6'd63);
        queue_word(40, 1'b1);
        set_width(6'd1);
        random_text(4, 3);

        // Random texts over several widths, mostly small sizes.
        for (int ph = 0; ph < 8; ph++)
        begin
            set_width(ph == 0 ? 6'd32 : ph == 1 ? 6'd2 : 6'($urandom_range(63)));
            calm = (ph == 3);
            random_text($urandom_range(14, 4), ph == 5 ? 12 : 6);
        end
        // Lower the width mid-line: the held line no longer fits.
        set_width(6'd32);
        queue_word(6, 1'b0);
        queue_word(6, 1'b0);
        queue_word(6, 1'b0);
        set_width(6'd9);
        queue_word(2, 1'b1);
        set_width(6'd20);
        calm = 1'b0;

        while (pending_words.size() > 0 || expected_chars.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (!failed && expected_chars.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: files.f
rtl/core/tfj_pkg.sv
rtl/core/tfj_ctrl.sv
rtl/core/tfj_dp.sv
rtl/core/text_full_justifier_top.sv
tb/sv/text_full_justifier_top_test.sv
